// ===== sv/hde_pkg.sv =====
// ----------------------------------------------------------------------------
// hde_pkg: shared types and constants for the Haar detail energy unit
// Widths of the band sums, the square-root radicand and the per-bit
// root stage record that travels down the cell chain.
// ----------------------------------------------------------------------------
package hde_pkg;

  localparam int PIX_W    = 8;
  localparam int ENERGY_W = 14;
  localparam int ROOT_W   = 14;                // one root bit per cell
  localparam int RAD_W    = 2 * ROOT_W;        // radicand, 64 * S, padded to even
  localparam int REM_W    = ROOT_W + 2;        // partial remainder
  localparam int SUM_W    = 21;                // S = LH^2 + HL^2 + HH^2 <= 1560600
  localparam int IN_TDATA_W  = 4 * PIX_W;
  localparam int OUT_TDATA_W = 16;

  // Record handed from one root cell to the next.
  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, top aligned
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

endpackage

// ===== sv/haar_detail_energy_unit.sv =====
// ----------------------------------------------------------------------------
// haar_detail_energy_unit: Haar lifting detail energy of a 2x2 pixel block
// Takes one 2x2 block per transfer and returns sqrt(LH^2 + HL^2 + HH^2)
// as unsigned Q.4, floored. One result per input block, in order.
// ----------------------------------------------------------------------------
// A new block is taken every cycle unless stalled; each result passes
// through seventeen registers to reach out_tvalid (two band/square stages,
// the first loading at the transfer edge itself, fourteen square-root cells
// producing one root bit each, one output register). Unstalled throughput is
// one block per cycle, set by the chain of root cells which all advance
// together. Output back-pressure stalls the whole chain once the output
// register and its skid register are both occupied; in_tready is a
// registered signal and does not depend combinationally on out_tready.
// No configuration, no state kept between blocks.
// ----------------------------------------------------------------------------
module haar_detail_energy_unit import hde_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input blocks
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] top_left, [15:8] top_right, [23:16] bottom_left, [31:24] bottom_right
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [13:0] energy (Q.4), [15:14] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Chain enable: everything advances unless the skid register is holding.
  logic        en;
  sqrt_stage_t chain [ROOT_W+1];

  // Output register plus one skid entry.
  logic                out_valid_r, out_valid_nxt;
  logic [ENERGY_W-1:0] out_data_r,  out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic [ENERGY_W-1:0] skid_data_r,  skid_data_nxt;
  logic                push;
  logic                pop;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Band values, squares and the 64*S radicand
  hde_band u_band (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .top_left     (in_tdata[7:0]),
    .top_right    (in_tdata[15:8]),
    .bottom_left  (in_tdata[23:16]),
    .bottom_right (in_tdata[31:24]),
    .stage_out    (chain[0])
  );

  // Root cells, most significant root bit first
  for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
    hde_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  assign push = chain[ROOT_W].valid && en;
  assign pop  = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // chain is frozen; drain the skid entry when the output frees up
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = chain[ROOT_W].root;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = chain[ROOT_W].root;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-ENERGY_W){1'b0}}, out_data_r};

`ifndef NO_ASSERTIONS
  // skid entry only ever sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds data while output register is empty");

  // a result leaving the chain always lands in the output stage
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("result from root chain was dropped");

  // skid fills only when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without output stall");

  // skid entry holds its data while the output is stalled (the chain is frozen while it is held)
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_tready) |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid entry changed while stalled");
`endif

endmodule

// ===== sv/hde_band.sv =====
// ----------------------------------------------------------------------------
// hde_band: Haar band values and sum of squares
// Stage 1 forms LH, HL, HH in half-pixel units and squares them; stage 2
// sums the squares and emits the radicand 64 * S for the root chain.
// ----------------------------------------------------------------------------
module hde_band import hde_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] top_left,
  input  logic [PIX_W-1:0] top_right,
  input  logic [PIX_W-1:0] bottom_left,
  input  logic [PIX_W-1:0] bottom_right,
  output sqrt_stage_t      stage_out
);

  logic signed [9:0]  d_top;
  logic signed [9:0]  d_bot;
  logic signed [10:0] lh;
  logic signed [10:0] hl;
  logic signed [10:0] dd;
  logic signed [11:0] hh;
  logic signed [21:0] lh_sq_full;
  logic signed [21:0] hl_sq_full;
  logic signed [23:0] hh_sq_full;

  logic              sq_valid_r;
  logic [17:0]       lh_sq_r;
  logic [17:0]       hl_sq_r;
  logic [19:0]       hh_sq_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              sum_valid_r;
  logic [SUM_W-1:0]  sum_r;

  assign d_top = $signed({2'b00, top_right}) - $signed({2'b00, top_left});
  assign d_bot = $signed({2'b00, bottom_right}) - $signed({2'b00, bottom_left});
  assign lh    = $signed({3'b000, bottom_left}) + $signed({3'b000, bottom_right})
               - $signed({3'b000, top_left}) - $signed({3'b000, top_right});
  assign hl    = $signed({d_top[9], d_top}) + $signed({d_bot[9], d_bot});
  assign dd    = $signed({d_bot[9], d_bot}) - $signed({d_top[9], d_top});
  assign hh    = {dd, 1'b0};

  assign lh_sq_full = lh * lh;
  assign hl_sq_full = hl * hl;
  assign hh_sq_full = hh * hh;

  assign sum_nxt = {3'b000, lh_sq_r} + {3'b000, hl_sq_r} + {1'b0, hh_sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
    end else if (en) begin
      sq_valid_r  <= in_valid;
      sum_valid_r <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lh_sq_r <= lh_sq_full[17:0];
      hl_sq_r <= hl_sq_full[17:0];
      hh_sq_r <= hh_sq_full[19:0];
      sum_r   <= sum_nxt;
    end
  end

  // radicand = 64 * S, one spare zero on top to make the width even
  assign stage_out = '{valid: sum_valid_r,
                       rad:   {1'b0, sum_r, 6'b000000},
                       rem:   '0,
                       root:  '0};

endmodule

// ===== sv/hde_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// hde_sqrt_cell: one bit of a digit-by-digit integer square root
// Brings down two radicand bits, tries root*4+1 against the remainder and
// shifts the resulting root bit in; registered hand-off to the next cell.
// ----------------------------------------------------------------------------
module hde_sqrt_cell import hde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  sqrt_stage_t stage_in,
  output sqrt_stage_t stage_out
);

  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic             fits;
  sqrt_stage_t      stage_nxt;
  sqrt_stage_t      stage_r;

  always_comb begin
    acc   = {stage_in.rem, stage_in.rad[RAD_W-1 -: 2]};
    trial = {2'b00, stage_in.root, 2'b01};
    fits  = (acc >= trial);
    stage_nxt.valid = stage_in.valid;
    stage_nxt.rad   = {stage_in.rad[RAD_W-3:0], 2'b00};
    if (fits) begin
      stage_nxt.rem  = REM_W'(acc - trial);
      stage_nxt.root = {stage_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      stage_nxt.rem  = REM_W'(acc);
      stage_nxt.root = {stage_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  // only the valid bit is reset; data fields just follow the enable
  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.rad  <= stage_nxt.rad;
      stage_r.rem  <= stage_nxt.rem;
      stage_r.root <= stage_nxt.root;
    end
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  assign stage_out = stage_r;

endmodule
